FILE: rtl/utf8_validating_decoder_unit_defines.svh
// assertion macros shared by the utf8 decoder rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef UTF8_VALIDATING_DECODER_UNIT_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define UVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("utf8 decoder check failed");

`define UVD_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`else

`define UVD_ASSERT(lbl, prop)
`define UVD_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

FILE: rtl/utf8vd_pkg.sv
// types, status codes and helpers for the utf8 decoder
// no dependencies
`timescale 1ns / 1ps

package utf8vd_pkg;

  localparam int unsigned CodeW   = 21;
  localparam int unsigned OffsetW = 16;

  // longest string length that still advances the byte offset
  localparam longint MaxTextBytes = 64'sd65536;
  localparam logic [OffsetW-1:0] OffsetLimit =
    ((MaxTextBytes - 1) < 64'sd65535) ? OffsetW'(MaxTextBytes - 1) : 16'hFFFF;

  localparam logic [CodeW-1:0] MaxScalar    = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrLo       = 21'h00D800;
  localparam logic [CodeW-1:0] SurrHi       = 21'h00DFFF;
  localparam logic [CodeW-1:0] SuppBase     = 21'h010000;
  localparam logic [CodeW-1:0] Floor2       = 21'h000080;
  localparam logic [CodeW-1:0] Floor3       = 21'h000800;
  localparam logic [CodeW-1:0] HighSurrBase = 21'h00D800;
  localparam logic [CodeW-1:0] LowSurrBase  = 21'h00DC00;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadLead   = 3'd1,
    StTruncated = 3'd2,
    StBadCont   = 3'd3,
    StOverlong  = 3'd4,
    StBadScalar = 3'd5
  } status_e;

  typedef struct packed {
    logic [CodeW-1:0]   code_unit;
    status_e            status;
    logic [OffsetW-1:0] error_offset;
    logic               last_of_run;
    logic               string_done;
  } result_t;

  // results of one byte handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // sequence length from a lead byte, 0 for a bad lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0)            len = 3'd1;
    else if (b[7:5] == 3'b110)   len = 3'd2;
    else if (b[7:4] == 4'b1110)  len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

endpackage

FILE: rtl/utf8vd_if.sv
// valid/ready channel interfaces: text bytes in, results out, format write
// depends on utf8vd_pkg
`timescale 1ns / 1ps

interface utf8vd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface utf8vd_result_if;
  import utf8vd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CodeW-1:0]   code_unit;
  logic [2:0]         status;
  logic [OffsetW-1:0] error_offset;
  logic               last_of_run;
  logic               string_done;

  modport source (output valid, code_unit, status, error_offset, last_of_run,
                  string_done, input ready);
  modport sink   (input valid, code_unit, status, error_offset, last_of_run,
                  string_done, output ready);
endinterface

interface utf8vd_cfg_if;
  logic valid;
  logic ready;
  logic output_format;

  modport source (output valid, output_format, input ready);
  modport sink   (input valid, output_format, output ready);
endinterface

FILE: rtl/utf8vd_decode.sv
// sequence state and single pass decode of one registered byte
// depends on utf8vd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "utf8_validating_decoder_unit_defines.svh"

module utf8vd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  input  logic              eot_i,
  input  logic              fmt_i,
  output utf8vd_pkg::push_t push_o
);
  import utf8vd_pkg::*;

  logic [2:0]         seq_len_q, seq_len_d;
  logic [1:0]         taken_q, taken_d;
  logic [CodeW-1:0]   partial_q, partial_d;
  logic [OffsetW-1:0] start_q, start_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic               disc_q, disc_d;

  logic [2:0]         len;
  logic [2:0]         taken_inc;
  logic [CodeW-1:0]   shifted;
  logic [CodeW-1:0]   floor_val;
  logic [CodeW-1:0]   cp;
  logic [CodeW-1:0]   supp;
  logic               char_en;
  status_e            err;
  logic [OffsetW-1:0] err_off;
  push_t              push;

  assign len       = lead_len(byte_i);
  assign taken_inc = {1'b0, taken_q} + 3'd1;
  assign shifted   = {partial_q[CodeW-7:0], byte_i[5:0]};

  always_comb begin
    unique case (seq_len_q)
      3'd2:    floor_val = Floor2;
      3'd3:    floor_val = Floor3;
      default: floor_val = SuppBase;
    endcase
  end

  always_comb begin
    seq_len_d = seq_len_q;
    taken_d   = taken_q;
    partial_d = partial_q;
    start_d   = start_q;
    disc_d    = disc_q;
    off_d     = off_q;
    char_en   = 1'b0;
    cp        = '0;
    err       = StOk;
    err_off   = '0;
    push      = '0;

    if (disc_q) begin
      // end marker while dropping the rest of a bad string
      if (eot_i) push.count = 2'd1;
    end else if (seq_len_q == 3'd0) begin
      if (len == 3'd0) begin
        err     = StBadLead;
        err_off = off_q;
      end else if (len == 3'd1) begin
        char_en = 1'b1;
        cp      = {{(CodeW-8){1'b0}}, byte_i};
      end else if (eot_i) begin
        err     = StTruncated;
        err_off = off_q;
      end else begin
        seq_len_d = len;
        taken_d   = 2'd1;
        start_d   = off_q;
        unique case (len)
          3'd2:    partial_d = {{(CodeW-5){1'b0}}, byte_i[4:0]};
          3'd3:    partial_d = {{(CodeW-4){1'b0}}, byte_i[3:0]};
          default: partial_d = {{(CodeW-3){1'b0}}, byte_i[2:0]};
        endcase
      end
    end else if (byte_i[7:6] != 2'b10) begin
      err     = StBadCont;
      err_off = start_q;
    end else begin
      partial_d = shifted;
      if (taken_inc >= seq_len_q) begin
        if (shifted < floor_val) begin
          err     = StOverlong;
          err_off = start_q;
        end else if (shifted > MaxScalar || (shifted >= SurrLo && shifted <= SurrHi)) begin
          err     = StBadScalar;
          err_off = start_q;
        end else begin
          char_en = 1'b1;
          cp      = shifted;
        end
        seq_len_d = 3'd0;
        taken_d   = 2'd0;
        partial_d = '0;
      end else if (eot_i) begin
        err     = StTruncated;
        err_off = start_q;
      end else begin
        taken_d = taken_inc[1:0];
      end
    end

    supp = cp - SuppBase;

    if (char_en) begin
      if (fmt_i && (cp > 21'h00FFFF)) begin
        push.count            = 2'd2;
        push.first.code_unit  = HighSurrBase | {{(CodeW-10){1'b0}}, supp[19:10]};
        push.second.code_unit = LowSurrBase  | {{(CodeW-10){1'b0}}, supp[9:0]};
      end else begin
        push.count           = 2'd1;
        push.first.code_unit = cp;
      end
    end

    if (err != StOk) begin
      push.count              = 2'd1;
      push.first              = '0;
      push.first.status       = err;
      push.first.error_offset = err_off;
      seq_len_d               = 3'd0;
      taken_d                 = 2'd0;
      partial_d               = '0;
      disc_d                  = !eot_i;
    end

    if (push.count == 2'd2) begin
      push.second.last_of_run = 1'b1;
      push.second.string_done = eot_i;
    end else if (push.count == 2'd1) begin
      push.first.last_of_run = 1'b1;
      push.first.string_done = eot_i;
    end

    if (eot_i) begin
      off_d     = '0;
      seq_len_d = 3'd0;
      taken_d   = 2'd0;
      partial_d = '0;
      disc_d    = 1'b0;
    end else if (off_q < OffsetLimit) begin
      off_d = off_q + 16'd1;
    end

    if (!advance_i) push.count = 2'd0;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= 3'd0;
      taken_q   <= 2'd0;
      partial_q <= '0;
      start_q   <= '0;
      off_q     <= '0;
      disc_q    <= 1'b0;
    end else if (advance_i) begin
      seq_len_q <= seq_len_d;
      taken_q   <= taken_d;
      partial_q <= partial_d;
      start_q   <= start_d;
      off_q     <= off_d;
      disc_q    <= disc_d;
    end
  end

  `UVD_ASSERT(a_disc_no_seq, disc_q |-> seq_len_q == 3'd0)
  `UVD_ASSERT(a_seq_len_legal,
    seq_len_q == 3'd0 || seq_len_q == 3'd2 || seq_len_q == 3'd3 || seq_len_q == 3'd4)
  `UVD_ASSERT(a_taken_in_range,
    (seq_len_q != 3'd0) |-> (taken_q != 2'd0 && {1'b0, taken_q} < seq_len_q))
  `UVD_ASSERT_MSG(a_eot_clears, (advance_i && eot_i) |=>
    (off_q == '0 && !disc_q && seq_len_q == 3'd0), "state not cleared after end of text")

endmodule

FILE: rtl/utf8vd_result_fifo.sv
// four entry result queue, takes up to two results per cycle, gives one
// depends on utf8vd_pkg, utf8vd_if and the assertion macro header
`timescale 1ns / 1ps
`include "utf8_validating_decoder_unit_defines.svh"

module utf8vd_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  utf8vd_pkg::push_t push_i,
  output logic              room_o,
  utf8vd_result_if.source   out
);
  import utf8vd_pkg::*;

  localparam int unsigned Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q, count_d;
  logic       pop;
  result_t    head;

  assign head      = mem_q[rd_ptr_q];
  assign pop       = out.valid && out.ready;
  assign room_o    = count_q <= 3'd2;
  assign count_d   = count_q + {1'b0, push_i.count} - {2'b00, pop};

  assign out.valid        = count_q != 3'd0;
  assign out.code_unit    = head.code_unit;
  assign out.status       = head.status;
  assign out.error_offset = head.error_offset;
  assign out.last_of_run  = head.last_of_run;
  assign out.string_done  = head.string_done;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.count;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_d;
    end
  end

  `UVD_ASSERT(a_count_bound, count_q <= 3'd4)
  `UVD_ASSERT_MSG(a_push_has_room, (push_i.count != 2'd0) |-> count_q <= 3'd2,
    "results pushed without room for a pair")
  `UVD_ASSERT(a_ptr_gap,
    wr_ptr_q == 2'(rd_ptr_q + count_q[1:0]))
  `UVD_ASSERT(a_count_track, ##1 count_q ==
    3'($past(count_q) + {1'b0, $past(push_i.count)} - {2'b00, $past(pop)}))

endmodule

FILE: rtl/utf8_validating_decoder_unit.sv
// top level of the streaming utf8 decoder and validator
// depends on utf8vd_pkg, utf8vd_if, utf8vd_decode and utf8vd_result_fifo
`timescale 1ns / 1ps

// Streaming UTF-8 decoder: takes one text byte per beat on in_i, with
// end_of_text on the last byte of each string, and gives code points (or
// UTF-16 code units, high surrogate first, when output_format is 1) on
// out_o. The first error in a string gives one result with a nonzero status
// and the offset of the failing sequence's first byte; the rest of the
// string is dropped, and its last byte gives a marker result with status 0
// and string_done set, so every string ends with a result. A byte is taken
// every cycle while the queue has room; each byte is held in the input
// register, decoded in one pass, and its results land in a four-entry queue,
// from which the head result is offered on out_o. Sustained throughput is one
// byte per cycle while each byte gives at most one result; the single result
// port moves one result a cycle, so surrogate pairs and a slow sink back up
// the queue, and the input stalls while fewer than two queue entries are free.
// output_format is written on cfg_i, always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module utf8_validating_decoder_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  utf8vd_byte_if.sink      in_i,
  utf8vd_result_if.source  out_o,
  utf8vd_cfg_if.sink       cfg_i
);
  import utf8vd_pkg::*;

  // format register, reset to code point output
  logic fmt_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;

  logic  room;     // queue can take a surrogate pair
  logic  advance;  // registered byte is decoded this cycle
  logic  in_take;  // input beat accepted
  push_t push;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.output_format;
    end
  end

  // the input register empties whenever its byte is decoded, so a new beat
  // can enter in the same cycle
  assign advance    = in_vld_q && room;
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.in_byte;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  // sequence tracking, checks and utf-16 split
  utf8vd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .eot_i     (in_eot_q),
    .fmt_i     (fmt_q),
    .push_o    (push)
  );

  // results wait here until the sink takes them
  utf8vd_result_fifo u_result_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out    (out_o)
  );

endmodule

FILE: dv/tb.sv
// self-checking testbench for utf8_validating_decoder_unit
// depends on utf8vd_pkg, the utf8vd channel interfaces and the decoder rtl
`timescale 1ns / 1ps

module tb;
  import utf8vd_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned IdleTail   = 12;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseBytes = 130;

  // expected-result store plus a bit-true copy of the decoder state
  class utf8_expect_board;
    result_t     expected_q[$];
    result_t     step_res[2];
    logic        fmt_utf16;
    logic [2:0]  seq_len;
    logic [1:0]  taken;
    logic [20:0] partial;
    logic [15:0] seq_start;
    logic [15:0] offset;
    logic        dropping;
    int          mismatches;
    int          checked;
    int          error_results;

    function new();
      fmt_utf16     = 1'b0;
      seq_len       = '0;
      taken         = '0;
      partial       = '0;
      seq_start     = '0;
      offset        = '0;
      dropping      = 1'b0;
      mismatches    = 0;
      checked       = 0;
      error_results = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_format(logic v);
      fmt_utf16 = v;
    endfunction

    function result_t make_res(logic [20:0] unit, status_e st, logic [15:0] off);
      result_t r;
      r.code_unit    = unit;
      r.status       = st;
      r.error_offset = off;
      r.last_of_run  = 1'b0;
      r.string_done  = 1'b0;
      return r;
    endfunction

    // one code point, or a surrogate pair in utf-16 mode
    function int emit_char(logic [20:0] cp);
      logic [20:0] v;
      if (fmt_utf16 && cp > 21'h00FFFF) begin
        v = cp - SuppBase;
        step_res[0] = make_res(HighSurrBase | 21'(v[19:10]), StOk, '0);
        step_res[1] = make_res(LowSurrBase | 21'(v[9:0]), StOk, '0);
        return 2;
      end
      step_res[0] = make_res(cp, StOk, '0);
      return 1;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      int          n;
      int          i;
      status_e     err;
      logic [15:0] err_off;
      logic [2:0]  len;
      logic [2:0]  next_taken;
      logic [20:0] flr;
      n       = 0;
      err     = StOk;
      err_off = '0;
      len     = '0;
      if (dropping) begin
        if (eot) begin
          step_res[0] = make_res('0, StOk, '0);
          n = 1;
        end
      end else if (seq_len == 3'd0) begin
        casez (b)
          8'b0???????: len = 3'd1;
          8'b110?????: len = 3'd2;
          8'b1110????: len = 3'd3;
          8'b11110???: len = 3'd4;
          default:     len = 3'd0;
        endcase
        if (len == 3'd0) begin
          err     = StBadLead;
          err_off = offset;
        end else if (len == 3'd1) begin
          n = emit_char(21'(b));
        end else if (eot) begin
          err     = StTruncated;
          err_off = offset;
        end else begin
          seq_len   = len;
          taken     = 2'd1;
          partial   = (len == 3'd2) ? 21'(b[4:0]) :
                      (len == 3'd3) ? 21'(b[3:0]) : 21'(b[2:0]);
          seq_start = offset;
        end
      end else if (b[7:6] != 2'b10) begin
        err     = StBadCont;
        err_off = seq_start;
      end else begin
        next_taken = 3'(taken) + 3'd1;
        partial    = {partial[14:0], b[5:0]};
        if (next_taken >= seq_len) begin
          flr = (seq_len == 3'd2) ? Floor2 : (seq_len == 3'd3) ? Floor3 : SuppBase;
          if (partial < flr) begin
            err     = StOverlong;
            err_off = seq_start;
          end else if (partial > MaxScalar || (partial >= SurrLo && partial <= SurrHi)) begin
            err     = StBadScalar;
            err_off = seq_start;
          end else begin
            n = emit_char(partial);
          end
          seq_len = '0;
          taken   = '0;
          partial = '0;
        end else if (eot) begin
          err     = StTruncated;
          err_off = seq_start;
        end else begin
          taken = next_taken[1:0];
        end
      end

      if (err != StOk) begin
        step_res[0] = make_res('0, err, err_off);
        n        = 1;
        seq_len  = '0;
        taken    = '0;
        partial  = '0;
        dropping = !eot;
        error_results++;
      end

      if (n > 0) begin
        step_res[n-1].last_of_run = 1'b1;
        if (eot) step_res[n-1].string_done = 1'b1;
      end
      for (i = 0; i < n; i++) expected_q.insert(expected_q.size(), step_res[i]);

      if (eot) begin
        offset   = '0;
        seq_len  = '0;
        taken    = '0;
        partial  = '0;
        dropping = 1'b0;
      end else if (offset < OffsetLimit) begin
        offset = offset + 16'd1;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("mismatch: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result unit %h status %0d offset %0d",
                         got.code_unit, got.status, got.error_offset));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.code_unit !== want.code_unit || got.status !== want.status ||
          got.error_offset !== want.error_offset || got.last_of_run !== want.last_of_run ||
          got.string_done !== want.string_done) begin
        report($sformatf("result %0d got %h/%0d/%0d/%b/%b want %h/%0d/%0d/%b/%b", checked,
                         got.code_unit, got.status, got.error_offset, got.last_of_run,
                         got.string_done, want.code_unit, want.status, want.error_offset,
                         want.last_of_run, want.string_done));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  utf8vd_byte_if   byte_ch ();
  utf8vd_result_if res_ch ();
  utf8vd_cfg_if    cfg_ch ();

  utf8_validating_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  utf8_expect_board sb;
  logic [7:0] text_q[$];
  int  bytes_sent;
  int  strings_sent;
  int  cycle_count;
  bit  src_idle;
  bit  sink_idle;
  bit  hold_req;
  int  four_bias;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: check every beat, then pick ready for the next cycle
  initial begin
    int      stall_left;
    int      hold_left;
    result_t got;
    stall_left   = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) begin
        got.code_unit    = res_ch.code_unit;
        got.status       = status_e'(res_ch.status);
        got.error_offset = res_ch.error_offset;
        got.last_of_run  = res_ch.last_of_run;
        got.string_done  = res_ch.string_done;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = HoldCycles - 1;
        hold_req <= 1'b0;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // one byte beat, called at a rising edge, returns at the accepting edge or after the idle gap that follows it
  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    byte_ch.valid       <= 1'b1;
    byte_ch.in_byte     <= b;
    byte_ch.end_of_text <= eot;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sb.note_byte(b, eot);
    bytes_sent++;
    gap = 0;
    if (src_idle && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    strings_sent++;
  endtask

  // wait for all results, plus an idle tail for bytes that give none
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_format(logic v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.output_format <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_format(v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // append one byte to the string being built
  function automatic void add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // encode cp in len bytes, no checks, so overlong and out-of-range forms too
  function automatic void push_char(logic [20:0] cp, int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_scalar(int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 127));
      2: cp = 21'($urandom_range(32'h80, 32'h7FF));
      3: begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= SurrLo && cp <= SurrHi) cp = cp ^ 21'h002000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  // random string: mostly well formed, some faults, some pure noise
  task automatic build_text();
    int          kind;
    int          nch;
    int          k;
    int          len;
    int          cut;
    logic [7:0]  b;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      nch = $urandom_range(1, 8);
      repeat (nch) add_byte(8'($urandom));
      return;
    end
    nch = (kind < 90) ? $urandom_range(1, 6) : $urandom_range(7, 16);
    for (k = 0; k < nch; k++) begin
      len = ($urandom_range(0, 99) < four_bias) ? 4 : $urandom_range(1, 4);
      if ($urandom_range(0, 99) < 88) begin
        cp = pick_scalar(len);
        // lean on the range edges now and then
        if ($urandom_range(0, 9) == 0) begin
          cp = (len == 1) ? 21'h7F : (len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : MaxScalar;
        end else if ($urandom_range(0, 9) == 0) begin
          cp = (len == 1) ? 21'h0 : (len == 2) ? Floor2 : (len == 3) ? Floor3 : SuppBase;
        end
        push_char(cp, len);
      end else begin
        if (len == 1) len = 2;
        case ($urandom_range(0, 6))
          0: add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF)) :
                                                    8'($urandom_range(8'hF8, 8'hFF)));
          1: begin
            push_char(pick_scalar(len), len);
            cut = $urandom_range(1, len - 1);
            repeat (cut) void'(text_q.pop_back());
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            add_byte(b);
          end
          2: push_char(21'($urandom_range(0, (len == 2) ? 32'h7F :
                                               (len == 3) ? 32'h7FF : 32'hFFFF)), len);
          3: push_char(21'($urandom_range(SurrLo, SurrHi)), 3);
          4: push_char(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
          5: begin
            // cut off by the end of the string
            push_char(pick_scalar(len), len);
            cut = $urandom_range(1, len - 1);
            repeat (cut) void'(text_q.pop_back());
            return;
          end
          default: begin
            add_byte(8'hC0 | 8'($urandom_range(0, 1)));
            add_byte(8'h80 | 8'($urandom_range(0, 63)));
          end
        endcase
      end
    end
  endtask

  task automatic random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      build_text();
      send_text();
    end
  endtask

  initial begin
    sb = new();
    bytes_sent   = 0;
    strings_sent = 0;
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    hold_req     = 1'b0;
    four_bias    = 0;
    byte_ch.valid        = 1'b0;
    byte_ch.in_byte      = '0;
    byte_ch.end_of_text  = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.output_format = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings in code point mode, straight from reset
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'hFF, 8'h41, 8'h42};           // bad lead, then dropped to the end
    send_text();
    text_q = '{8'hC0, 8'h80};                  // overlong error on the last byte
    send_text();
    text_q = '{8'hE2, 8'h41};                  // bad continuation wins over truncation
    send_text();
    text_q = '{8'hF0, 8'h9F};                  // truncated by end of text
    send_text();
    text_q = '{8'hED, 8'hA0, 8'h80, 8'h7F};    // surrogate
    send_text();
    text_q = '{8'hF5, 8'h80, 8'h80, 8'h80};    // above the last scalar
    send_text();
    drain();

    // utf-16 with idling on both sides
    write_format(1'b1);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    random_phase();
    drain();

    // code points at full rate
    write_format(1'b0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    random_phase();
    drain();

    // utf-16, mostly 4-byte chars, sink held off so the queue fills
    write_format(1'b1);
    four_bias = 60;
    hold_req <= 1'b1;
    random_phase();
    four_bias = 0;
    drain();

    // code points with idling again
    write_format(1'b0);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    random_phase();
    drain();

    $display("covered %0d bytes in %0d strings in both output formats,", bytes_sent,
             strings_sent);
    $display("with idling, a long sink stall, %0d results checked, %0d errors, %0d mismatches",
             sb.checked, sb.error_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
